/* sv/cct_pkg.sv */
// Shared types and constants for the chunk completion tracker.
package cct_pkg;

	localparam int MaxChunks = 1024;
	localparam int IdxW      = $clog2(MaxChunks);
	localparam int CntW      = IdxW + 1;

	localparam logic [CntW-1:0] CountReset = CntW'(1);
	localparam logic [CntW-1:0] CountMax   = {CntW{1'b1}};
	localparam logic [IdxW-1:0] LastIdx    = IdxW'(MaxChunks - 1);

	// Item modes
	localparam logic MODE_QUERY = 1'b0;
	localparam logic MODE_MARK  = 1'b1;

	typedef struct packed {
		logic            mode;
		logic [IdxW-1:0] chunk_index;
	} cct_in_t;

	typedef struct packed {
		logic            in_range;
		logic            was_done;
		logic            newly_marked;
		logic [CntW-1:0] completed_count;
	} cct_out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clear_en;
		logic accept;
		logic exec;
	} cct_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_last;
	} cct_stat_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} cct_state_t;

endpackage

/* sv/chunk_completion_tracker_unit.sv */
// Top level of the chunk completion tracker: controller plus datapath.
//
//  channel   signals                 direction  handshake
//  item      start, item, busy       in         taken when start & !busy
//  result    done, result            out        one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_data        in         written when cfg_we
//
// For each item the bitmap memory read is registered first, then the
// bit is tested, set and the count updated; done pulses the cycle after that,
// and busy is already low then, so the next item can be accepted while done pulses.
// After reset a clearing pass zeroes the 1024-entry bitmap, one entry per
// cycle, with busy high. Results cannot be stalled.
module chunk_completion_tracker_unit import cct_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  cct_in_t         item,
	input  logic            cfg_we,
	input  logic [CntW-1:0] cfg_data,
	output logic            done,
	output cct_out_t        result
);

	cct_cmd_t  cmd;
	cct_stat_t stat;

	cct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	cct_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result)
	);

endmodule

/* sv/cct_datapath.sv */
// Datapath: done bitmap memory, chunk limit, completed count and result register.
module cct_datapath import cct_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cct_cmd_t        cmd,
	output cct_stat_t       stat,
	input  cct_in_t         item,
	input  logic            cfg_we,
	input  logic [CntW-1:0] cfg_data,
	output logic            done,
	output cct_out_t        result
);

	logic            bits_mem [MaxChunks];
	logic            rd_q;
	logic            mode_q;
	logic [IdxW-1:0] idx_q;
	logic [IdxW-1:0] clr_q;
	logic [CntW-1:0] chunk_count_q;
	logic [CntW-1:0] total_q;
	logic            done_q;
	cct_out_t        result_q;

	logic            in_rng;
	logic            fresh;
	logic [CntW-1:0] total_nxt;

	// Work out the beat's result from the registered bit
	always_comb begin
		in_rng    = {1'b0, idx_q} < chunk_count_q;
		fresh     = in_rng && (mode_q == MODE_MARK) && !rd_q;
		total_nxt = (fresh && (total_q != CountMax)) ? total_q + CntW'(1) : total_q;
	end

	// Bitmap memory: one write port shared by the clearing pass and marks
	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			bits_mem[clr_q] <= 1'b0;
		end else if (cmd.exec && fresh) begin
			bits_mem[idx_q] <= 1'b1;
		end
		if (cmd.accept) begin
			rd_q <= bits_mem[item.chunk_index];
		end
	end

	// Hold the accepted beat and the result
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= item.mode;
			idx_q  <= item.chunk_index;
		end
		if (cmd.exec) begin
			result_q.in_range        <= in_rng;
			result_q.was_done        <= in_rng & rd_q;
			result_q.newly_marked    <= fresh;
			result_q.completed_count <= total_nxt;
		end
	end

	// Control state: clear counter, limit register, count, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q         <= '0;
			chunk_count_q <= CountReset;
			total_q       <= '0;
			done_q        <= 1'b0;
		end else begin
			if (cmd.clear_en) begin
				clr_q <= clr_q + IdxW'(1);
			end
			if (cfg_we) begin
				chunk_count_q <= cfg_data;
			end
			if (cmd.exec) begin
				total_q <= total_nxt;
			end
			done_q <= cmd.exec;
		end
	end

	assign stat.clear_last = (clr_q == LastIdx);
	assign done            = done_q;
	assign result          = result_q;

endmodule

/* sv/cct_ctrl.sv */
// Controller: clearing pass after reset, then accept and execute one beat at a time.
module cct_ctrl import cct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cct_stat_t stat,
	output cct_cmd_t  cmd,
	output logic      busy
);

	cct_state_t state_q;
	cct_state_t state_nxt;

	// Next state and commands
	always_comb begin
		state_nxt    = state_q;
		cmd.clear_en = 1'b0;
		cmd.accept   = 1'b0;
		cmd.exec     = 1'b0;
		busy         = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (stat.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* tb/sv/cct_checker.sv */
// Checker for the chunk completion tracker: predicts each result beat and compares it.
module cct_checker import cct_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  cct_in_t         item,
	input  logic            cfg_we,
	input  logic [CntW-1:0] cfg_data,
	input  logic            done,
	input  cct_out_t        result,
	output int              fail_count,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Own copy of the tracker state
	logic [MaxChunks-1:0] done_map;
	logic [CntW-1:0]      done_sum;
	logic [CntW-1:0]      chunk_reg;
	cct_out_t             expected_beats[$];

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Work out the beat for one accepted item and advance the state
	function automatic cct_out_t track_chunk(input cct_in_t beat);
		cct_out_t res;
		int lim;
		res = '0;
		lim = (int'(chunk_reg) > MaxChunks) ? MaxChunks : int'(chunk_reg);
		if (int'(beat.chunk_index) < lim) begin
			res.in_range = 1'b1;
			res.was_done = done_map[beat.chunk_index];
			if (beat.mode == MODE_MARK && !res.was_done) begin
				done_map[beat.chunk_index] = 1'b1;
				res.newly_marked = 1'b1;
				if (done_sum != CountMax)
					done_sum = done_sum + CntW'(1);
			end
		end
		res.completed_count = done_sum;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cct_out_t want;
		if (!arst_n) begin
			done_map = '0;
			done_sum = '0;
			chunk_reg = CountReset;
			expected_beats.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// Compare a result beat with the oldest expectation
			if (done) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("result beat with nothing outstanding", 1, 0);
				end else begin
					want = expected_beats.pop_front();
					if (result.in_range !== want.in_range)
						report_mismatch("in_range", int'(result.in_range),
							int'(want.in_range));
					if (result.was_done !== want.was_done)
						report_mismatch("was_done", int'(result.was_done),
							int'(want.was_done));
					if (result.newly_marked !== want.newly_marked)
						report_mismatch("newly_marked", int'(result.newly_marked),
							int'(want.newly_marked));
					if (result.completed_count !== want.completed_count)
						report_mismatch("completed_count", int'(result.completed_count),
							int'(want.completed_count));
				end
			end
			// Track the chunk count register
			if (cfg_we)
				chunk_reg = cfg_data;
			// Predict the beat for an accepted item
			if (start && !busy)
				expected_beats.push_back(track_chunk(item));
			pending = expected_beats.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the chunk completion tracker: stimulus, checker and verdict.
module tb import cct_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	cct_in_t         item;
	logic            cfg_we;
	logic [CntW-1:0] cfg_data;
	logic            done;
	cct_out_t        result;
	int              fail_count;
	int              pending;
	int              idle_pct;

	chunk_completion_tracker_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result)
	);

	cct_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 8 ns clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Hand one item to the block, idling first at the current rate; start stays high after
	task automatic issue(input logic m, input logic [IdxW-1:0] ix);
		logic taken;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		item.mode = m;
		item.chunk_index = ix;
		do begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end while (!taken);
	endtask

	// Drop start and hold until every outstanding beat has come back
	task automatic drain();
		start = 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
	endtask

	// Write the chunk count with the block idle
	task automatic set_chunks(input logic [CntW-1:0] value);
		drain();
		cfg_we = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Random phase: mostly in-range indices, marks a little more often than queries
	task automatic random_phase(input logic [CntW-1:0] chunks, input int pct, input int n);
		int lim;
		logic [IdxW-1:0] ix;
		set_chunks(chunks);
		idle_pct = pct;
		lim = (int'(chunks) > MaxChunks) ? MaxChunks : int'(chunks);
		repeat (n) begin
			if (lim > 0 && $urandom_range(99) < 80)
				ix = IdxW'($urandom_range(lim - 1));
			else
				ix = IdxW'($urandom_range(MaxChunks - 1));
			issue(($urandom_range(99) < 60) ? MODE_MARK : MODE_QUERY, ix);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset count of one chunk
		drain();
		issue(MODE_QUERY, '0);
		issue(MODE_QUERY, IdxW'(1));
		issue(MODE_QUERY, LastIdx);
		issue(MODE_MARK, '0);
		issue(MODE_MARK, '0);
		issue(MODE_QUERY, '0);
		issue(MODE_MARK, IdxW'(5));
		// Zero chunks: everything out of range
		set_chunks('0);
		issue(MODE_QUERY, '0);
		issue(MODE_MARK, '0);
		issue(MODE_MARK, LastIdx);
		// Count above the bitmap size clamps to the full bitmap
		set_chunks(CountMax);
		issue(MODE_MARK, LastIdx);
		issue(MODE_QUERY, LastIdx);
		issue(MODE_MARK, IdxW'(512));
		issue(MODE_QUERY, IdxW'(512));
		issue(MODE_MARK, IdxW'(341));
		set_chunks(CntW'(MaxChunks));
		issue(MODE_MARK, LastIdx);
		issue(MODE_QUERY, IdxW'(682));
		// Shrink after marks: old bits stay, count keeps its value
		set_chunks(CntW'(1));
		issue(MODE_QUERY, LastIdx);
		issue(MODE_MARK, LastIdx);
		issue(MODE_QUERY, '0);
		set_chunks(CntW'(1000));
		issue(MODE_QUERY, IdxW'(512));
		issue(MODE_MARK, IdxW'(999));
		issue(MODE_MARK, IdxW'(1000));

		// Random phases across counts and sender idle rates
		random_phase(CntW'(MaxChunks), 0, 250);
		random_phase(CntW'(8), 67, 250);
		random_phase(CountMax, 8, 250);
		random_phase('0, 0, 150);
		random_phase(CntW'(300), 67, 250);
		random_phase(CntW'(1), 8, 150);
		random_phase(CntW'($urandom_range(MaxChunks, 1)), 0, 250);
		random_phase(CntW'(MaxChunks), 67, 200);

		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Hard stop if the run hangs
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

/* filelist.f */
sv/cct_pkg.sv
sv/cct_datapath.sv
sv/cct_ctrl.sv
sv/chunk_completion_tracker_unit.sv
tb/sv/cct_checker.sv
tb/sv/tb.sv
